FILE: design/afu_pkg.sv
// Shared types, flag bit positions and operation codes for the arithmetic flags unit.
package afu_pkg;

  localparam int unsigned FlagsW = 12;

  localparam logic [FlagsW-1:0] FL_CF       = 12'h001;
  localparam logic [FlagsW-1:0] FL_ONE      = 12'h002;
  localparam logic [FlagsW-1:0] FL_PF       = 12'h004;
  localparam logic [FlagsW-1:0] FL_AF       = 12'h010;
  localparam logic [FlagsW-1:0] FL_ZF       = 12'h040;
  localparam logic [FlagsW-1:0] FL_SF       = 12'h080;
  localparam logic [FlagsW-1:0] FL_OF       = 12'h800;
  localparam logic [FlagsW-1:0] FL_ARITH    = 12'h8D5;
  localparam logic [FlagsW-1:0] FL_LOADMASK = 12'hFD7;
  localparam logic [FlagsW-1:0] FL_RESET    = 12'h002;
  localparam logic [FlagsW-1:0] FL_ALL      = 12'hFFF;
  localparam logic [FlagsW-1:0] FL_NONE     = 12'h000;

  typedef enum logic [3:0] {
    OP_LOGIC  = 4'd0,
    OP_ADD    = 4'd1,
    OP_ADC    = 4'd2,
    OP_SUB    = 4'd3,
    OP_SBB    = 4'd4,
    OP_INC    = 4'd5,
    OP_DEC    = 4'd6,
    OP_NEG    = 4'd7,
    OP_SHL    = 4'd8,
    OP_SHR    = 4'd9,
    OP_SAR    = 4'd10,
    OP_ROL    = 4'd11,
    OP_ROR    = 4'd12,
    OP_MUL_OV = 4'd13,
    OP_LOAD   = 4'd14,
    OP_READ   = 4'd15
  } op_e;

  typedef enum logic [1:0] {
    SZ_BYTE  = 2'd0,
    SZ_WORD  = 2'd1,
    SZ_DWORD = 2'd2,
    SZ_QWORD = 2'd3
  } size_e;

  // A decoded flag update: bits set in mask take their value from value,
  // the others keep the current flags register.
  typedef struct packed {
    logic [FlagsW-1:0] mask;
    logic [FlagsW-1:0] value;
  } update_t;

endpackage

FILE: design/afu_front.sv
// Front end: accepts operations, computes the flag update and registers it.
module afu_front import afu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [3:0]        req_type_i,
  input  logic [1:0]        size_code_i,
  input  logic [63:0]       operand_i,
  input  logic [63:0]       result_i,
  input  logic              carry_in_i,
  input  logic [5:0]        count_i,
  input  logic [11:0]       flags_value_i,
  output logic              upd_valid_o,
  input  logic              upd_ready_i,
  output update_t           upd_o
);

  logic    valid_q, valid_d;
  update_t upd_q, upd_d;
  logic    accept;

  logic [63:0] m, sb, orig, r, a_add, a_sub, sh_src, r_sh;
  logic [6:0]  width, cnt7, sh_idx;
  logic        zf, sf, pf, cf, af, of;
  logic        c_adc, c_sbb, r_sign, o_sign, in_range;
  op_e         op;

  assign op = op_e'(req_type_i);

  always_comb begin
    unique case (size_e'(size_code_i))
      SZ_BYTE:  m = 64'h0000_0000_0000_00FF;
      SZ_WORD:  m = 64'h0000_0000_0000_FFFF;
      SZ_DWORD: m = 64'h0000_0000_FFFF_FFFF;
      SZ_QWORD: m = 64'hFFFF_FFFF_FFFF_FFFF;
      default:  m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
  end

  assign width  = 7'd8 << size_code_i;
  assign sb     = ~(m >> 1) & m;
  assign orig   = operand_i & m;
  assign r      = result_i & m;
  assign r_sign = |(r & sb);
  assign o_sign = |(orig & sb);
  assign zf     = (r == 64'd0);
  assign sf     = r_sign;
  assign pf     = ~^r[7:0];

  assign c_adc = (op == OP_ADC) && carry_in_i;
  assign c_sbb = (op == OP_SBB) && carry_in_i;
  // The first operand is recovered from the result and the second operand.
  assign a_add = (r - orig - {63'd0, c_adc}) & m;
  assign a_sub = (r + orig + {63'd0, c_sbb}) & m;

  assign cnt7     = {1'b0, count_i};
  assign in_range = (cnt7 <= width);
  assign sh_idx   = (op == OP_SHL) ? (width - cnt7) : (cnt7 - 7'd1);
  assign sh_src   = orig >> sh_idx[5:0];
  assign r_sh     = r >> (width - 7'd2);

  always_comb begin
    cf = 1'b0;
    af = 1'b0;
    of = 1'b0;
    upd_d.mask = FL_ARITH;
    unique case (op)
      OP_LOGIC: ;
      OP_ADD, OP_ADC: begin
        cf = c_adc ? (r <= orig) : (r < orig);
        of = |((a_add ^ r) & (orig ^ r) & sb);
        af = a_add[4] ^ orig[4] ^ r[4];
      end
      OP_SUB, OP_SBB: begin
        cf = c_sbb ? (a_sub <= orig) : (a_sub < orig);
        of = |((a_sub ^ orig) & (a_sub ^ r) & sb);
        af = a_sub[4] ^ orig[4] ^ r[4];
      end
      OP_INC: begin
        of = (r == sb);
        af = (r[3:0] == 4'h0);
        upd_d.mask = FL_ARITH & ~FL_CF;
      end
      OP_DEC: begin
        of = (r == (sb - 64'd1));
        af = (r[3:0] == 4'hF);
        upd_d.mask = FL_ARITH & ~FL_CF;
      end
      OP_NEG: begin
        cf = (orig != 64'd0);
        of = (orig == sb);
        af = orig[4] ^ r[4];
      end
      OP_SHL, OP_SHR, OP_SAR: begin
        if (in_range) begin
          cf = sh_src[0];
        end else begin
          cf = (op == OP_SAR) && o_sign;
        end
        if (count_i == 6'd1) begin
          if (op == OP_SHL) begin
            of = r_sign ^ cf;
          end else if (op == OP_SHR) begin
            of = o_sign;
          end
        end
        if (count_i == 6'd0) begin
          upd_d.mask = FL_NONE;
        end
      end
      OP_ROL, OP_ROR: begin
        cf = (op == OP_ROL) ? r[0] : r_sign;
        of = (op == OP_ROL) ? (r_sign ^ cf) : (cf ^ r_sh[0]);
        if (count_i == 6'd0) begin
          upd_d.mask = FL_NONE;
        end else if (count_i == 6'd1) begin
          upd_d.mask = FL_CF | FL_OF;
        end else begin
          upd_d.mask = FL_CF;
        end
      end
      OP_MUL_OV: begin
        cf = carry_in_i;
        of = carry_in_i;
        upd_d.mask = FL_CF | FL_OF;
      end
      OP_LOAD: upd_d.mask = FL_ALL;
      OP_READ: upd_d.mask = FL_NONE;
      default: upd_d.mask = FL_NONE;
    endcase
    if (op == OP_LOAD) begin
      upd_d.value = (flags_value_i & FL_LOADMASK) | FL_ONE;
    end else begin
      upd_d.value = {of, 3'b000, sf, zf, 1'b0, af, 1'b0, pf, 1'b1, cf};
    end
  end

  assign full   = valid_q && !upd_ready_i;
  assign accept = push && !full;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (upd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      upd_q <= upd_d;
    end
  end

  assign upd_valid_o = valid_q;
  assign upd_o       = upd_q;

endmodule

FILE: design/afu_queue.sv
// Two-entry queue of decoded flag updates between the front and back ends.
module afu_queue import afu_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  update_t in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output update_t out_data_o
);

  update_t     entry_q [2];
  logic        wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        wr_en, rd_en;

  assign in_ready_o  = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign wr_en       = in_valid_i && in_ready_o;
  assign rd_en       = out_valid_o && out_ready_i;
  assign out_data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ wr_en;
    rd_ptr_d = rd_ptr_q ^ rd_en;
    count_d  = count_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

FILE: design/afu_back.sv
// Back end: applies flag updates to the flags register and holds the result for pop.
module afu_back import afu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        upd_valid_i,
  output logic        upd_ready_o,
  input  update_t     upd_i,
  output logic        empty,
  input  logic        pop,
  output logic [11:0] flags_o
);

  logic [11:0] flags_q, flags_d;
  logic [11:0] out_q;
  logic        out_valid_q, out_valid_d;
  logic        take;

  assign upd_ready_o = !out_valid_q || pop;
  assign take        = upd_valid_i && upd_ready_o;
  assign flags_d     = (flags_q & ~upd_i.mask) | (upd_i.value & upd_i.mask) | FL_ONE;

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= FL_RESET;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        flags_q <= flags_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= flags_d;
    end
  end

  assign empty   = !out_valid_q;
  assign flags_o = out_q;

endmodule

FILE: design/x86_arith_flags_unit.sv
// Top level of the arithmetic flags unit: front end, update queue and back end.
//
// The unit keeps a 12-bit flags register and answers every operation pushed in
// with the value of that register after the operation. It takes one operation
// per clock cycle while full is low; a result reaches the result ports after
// passing the front register and an entry of the update queue into the output
// register. The flags register is updated in the back end as it takes each
// update. Either side may stall freely: the queue and front register hold
// further pushes while an earlier result waits to be popped, until full rises.
module x86_arith_flags_unit import afu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [3:0]  req_type_i,
  input  logic [1:0]  size_code_i,
  input  logic [63:0] operand_i,
  input  logic [63:0] result_i,
  input  logic        carry_in_i,
  input  logic [5:0]  count_i,
  input  logic [11:0] flags_value_i,
  output logic        empty,
  input  logic        pop,
  output logic [11:0] flags_o
);

  logic    f_valid, f_ready, b_valid, b_ready;
  update_t f_upd, b_upd;

  afu_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .req_type_i    (req_type_i),
    .size_code_i   (size_code_i),
    .operand_i     (operand_i),
    .result_i      (result_i),
    .carry_in_i    (carry_in_i),
    .count_i       (count_i),
    .flags_value_i (flags_value_i),
    .upd_valid_o   (f_valid),
    .upd_ready_i   (f_ready),
    .upd_o         (f_upd)
  );

  afu_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_data_i   (f_upd),
    .out_valid_o (b_valid),
    .out_ready_i (b_ready),
    .out_data_o  (b_upd)
  );

  afu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_valid_i (b_valid),
    .upd_ready_o (b_ready),
    .upd_i       (b_upd),
    .empty       (empty),
    .pop         (pop),
    .flags_o     (flags_o)
  );

endmodule

FILE: tb/x86_arith_flags_unit_test.sv
// Self-checking testbench for the x86 arithmetic flags unit.
module x86_arith_flags_unit_test;
  import afu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomOps  = 1050;
  localparam int CycleLimit = 200000;
  localparam int ShownErrs  = 10;

  typedef struct {
    op_e         kind;
    size_e       size;
    logic [63:0] operand;
    logic [63:0] result;
    logic        carry;
    logic [5:0]  count;
    logic [11:0] load_val;
  } flag_op_t;

  typedef struct {
    flag_op_t    op;
    logic        typed;
    logic [11:0] want;
  } plan_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [3:0]  req_type_i;
  logic [1:0]  size_code_i;
  logic [63:0] operand_i;
  logic [63:0] result_i;
  logic        carry_in_i;
  logic [5:0]  count_i;
  logic [11:0] flags_value_i;
  logic        empty;
  logic        pop;
  logic [11:0] flags_o;

  logic [11:0] flags_shadow;
  logic [11:0] flags_due[$];
  plan_row_t   plan[$];
  bit          calm;
  int          flag_errors;
  int          results_checked;
  int          ops_sent;
  int          op_seen[16];
  int          cycles;

  x86_arith_flags_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .req_type_i   (req_type_i),
    .size_code_i  (size_code_i),
    .operand_i    (operand_i),
    .result_i     (result_i),
    .carry_in_i   (carry_in_i),
    .count_i      (count_i),
    .flags_value_i(flags_value_i),
    .empty        (empty),
    .pop          (pop),
    .flags_o      (flags_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results still outstanding", cycles,
               flags_due.size());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [11:0] with_flag(logic [11:0] f, logic [11:0] fbit, logic on);
    return on ? (f | fbit) : (f & ~fbit);
  endfunction

  function automatic logic [11:0] with_zsp(logic [11:0] f, logic [63:0] r, logic [63:0] sb);
    f = with_flag(f, FL_ZF, r == 64'd0);
    f = with_flag(f, FL_SF, (r & sb) != 64'd0);
    f = with_flag(f, FL_PF, ~^r[7:0]);
    return f;
  endfunction

  function automatic logic [63:0] size_mask(size_e sz);
    return (sz == SZ_QWORD) ? {64{1'b1}} : ((64'd1 << (8 << sz)) - 64'd1);
  endfunction

  // Flags register after one operation, given the register before it.
  function automatic logic [11:0] next_flags(flag_op_t op, logic [11:0] prior);
    int          w;
    int          cnt;
    logic [63:0] m;
    logic [63:0] sb;
    logic [63:0] b;
    logic [63:0] r;
    logic [63:0] a;
    logic [63:0] c;
    logic [11:0] f;
    logic        cf;
    w   = 8 << op.size;
    cnt = op.count;
    m   = size_mask(op.size);
    sb  = 64'd1 << (w - 1);
    b   = op.operand & m;
    r   = op.result & m;
    c   = {63'd0, op.carry};
    f   = FL_ONE;
    case (op.kind)
      OP_LOGIC: begin
        f = with_zsp(f, r, sb);
      end
      OP_ADD, OP_ADC: begin
        a = (r - b - ((op.kind == OP_ADC) ? c : 64'd0)) & m;
        f = with_zsp(f, r, sb);
        f = with_flag(f, FL_CF, (op.kind == OP_ADC && op.carry) ? (r <= b) : (r < b));
        f = with_flag(f, FL_OF, (((a ^ r) & (b ^ r)) & sb) != 64'd0);
        f = with_flag(f, FL_AF, a[4] ^ b[4] ^ r[4]);
      end
      OP_SUB, OP_SBB: begin
        a = (r + b + ((op.kind == OP_SBB) ? c : 64'd0)) & m;
        f = with_zsp(f, r, sb);
        f = with_flag(f, FL_CF, (op.kind == OP_SBB && op.carry) ? (a <= b) : (a < b));
        f = with_flag(f, FL_OF, (((a ^ b) & (a ^ r)) & sb) != 64'd0);
        f = with_flag(f, FL_AF, a[4] ^ b[4] ^ r[4]);
      end
      OP_INC, OP_DEC: begin
        a = (op.kind == OP_INC) ? ((r - 64'd1) & m) : ((r + 64'd1) & m);
        f = with_zsp(f, r, sb);
        f = with_flag(f, FL_CF, (prior & FL_CF) != '0);
        if (op.kind == OP_INC) f = with_flag(f, FL_OF, a == sb - 64'd1 && (r & sb) != 64'd0);
        else f = with_flag(f, FL_OF, a == sb && (r & sb) == 64'd0);
        f = with_flag(f, FL_AF, a[4] ^ r[4]);
      end
      OP_NEG: begin
        f = with_zsp(f, r, sb);
        f = with_flag(f, FL_CF, b != 64'd0);
        f = with_flag(f, FL_OF, b == sb);
        f = with_flag(f, FL_AF, b[4] ^ r[4]);
      end
      OP_SHL, OP_SHR, OP_SAR: begin
        if (cnt == 0) return prior;
        f = with_zsp(f, r, sb);
        if (cnt <= w) cf = (op.kind == OP_SHL) ? b[w - cnt] : b[cnt - 1];
        else cf = (op.kind == OP_SAR) && (b & sb) != 64'd0;
        f = with_flag(f, FL_CF, cf);
        if (cnt == 1 && op.kind == OP_SHL) f = with_flag(f, FL_OF, ((r & sb) != 64'd0) != cf);
        if (cnt == 1 && op.kind == OP_SHR) f = with_flag(f, FL_OF, (b & sb) != 64'd0);
      end
      OP_ROL, OP_ROR: begin
        if (cnt == 0) return prior;
        f  = prior;
        cf = (op.kind == OP_ROL) ? r[0] : ((r & sb) != 64'd0);
        f  = with_flag(f, FL_CF, cf);
        if (cnt == 1) begin
          if (op.kind == OP_ROL) f = with_flag(f, FL_OF, ((r & sb) != 64'd0) != cf);
          else f = with_flag(f, FL_OF, cf != ((r & (sb >> 1)) != 64'd0));
        end
      end
      OP_MUL_OV: begin
        f = with_flag(prior, FL_CF, op.carry);
        f = with_flag(f, FL_OF, op.carry);
      end
      OP_LOAD: begin
        return (op.load_val & FL_LOADMASK) | FL_ONE;
      end
      default: begin
        return prior;
      end
    endcase
    return (prior & ~(FL_ARITH | FL_ONE)) | (f & FL_ARITH) | FL_ONE;
  endfunction

  // Boundary values half the time, else small or random ones; sometimes junk above the operand width.
  function automatic logic [63:0] pick_value(size_e sz);
    logic [63:0] m;
    logic [63:0] sb;
    logic [63:0] v;
    m  = size_mask(sz);
    sb = 64'd1 << ((8 << sz) - 1);
    case ($urandom_range(7))
      0: v = 64'd0;
      1: v = m;
      2: v = sb;
      3: v = sb - 64'd1;
      4: v = 64'($urandom_range(31));
      default: v = {$urandom, $urandom};
    endcase
    if ($urandom_range(3) == 0) v |= {$urandom, $urandom} & ~m;
    return v;
  endfunction

  // A random operation whose result usually matches what the operation would produce.
  function automatic flag_op_t random_op();
    flag_op_t    op;
    int          w;
    int          k;
    logic [63:0] m;
    logic [63:0] sb;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] r;
    logic [63:0] sx;
    op.kind     = op_e'($urandom_range(15));
    op.size     = size_e'($urandom_range(3));
    op.carry    = 1'($urandom_range(1));
    op.load_val = 12'($urandom_range(4095));
    w  = 8 << op.size;
    m  = size_mask(op.size);
    sb = 64'd1 << (w - 1);
    case ($urandom_range(7))
      0:       op.count = 6'd0;
      1, 2:    op.count = 6'd1;
      3, 4, 5: op.count = 6'($urandom_range(1, (w > 63) ? 63 : w));
      default: op.count = 6'($urandom_range(63));
    endcase
    x = pick_value(op.size);
    y = pick_value(op.size);
    op.operand = y;
    y = y & m;
    k = op.count % w;
    sx = (y ^ sb) - sb;
    case (op.kind)
      OP_LOGIC: r = $urandom_range(1) ? (x & y) : (x ^ y);
      OP_ADD:   r = x + y;
      OP_ADC:   r = x + y + op.carry;
      OP_SUB:   r = x - y;
      OP_SBB:   r = x - y - op.carry;
      OP_INC:   r = x + 64'd1;
      OP_DEC:   r = x - 64'd1;
      OP_NEG:   r = 64'd0 - y;
      OP_SHL:   r = y << op.count;
      OP_SHR:   r = y >> op.count;
      OP_SAR:   r = $signed(sx) >>> op.count;
      OP_ROL:   r = (y << k) | (y >> (w - k));
      OP_ROR:   r = (y >> k) | (y << (w - k));
      default:  r = x;
    endcase
    r = r & m;
    if ($urandom_range(7) == 0) r = pick_value(op.size);
    else if ($urandom_range(3) == 0) r |= {$urandom, $urandom} & ~m;
    op.result = r;
    return op;
  endfunction

  task automatic add_row(op_e kind, size_e size, logic [63:0] operand, logic [63:0] result,
                         logic carry, logic [5:0] count, logic [11:0] load_val,
                         logic typed, logic [11:0] want);
    plan_row_t row;
    row.op.kind     = kind;
    row.op.size     = size;
    row.op.operand  = operand;
    row.op.result   = result;
    row.op.carry    = carry;
    row.op.count    = count;
    row.op.load_val = load_val;
    row.typed       = typed;
    row.want        = want;
    plan.push_back(row);
  endtask

  task automatic transfer_in(flag_op_t op, logic typed, logic [11:0] want);
    logic [11:0] nxt;
    while (!calm && $urandom_range(99) < 27) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    req_type_i    <= op.kind;
    size_code_i   <= op.size;
    operand_i     <= op.operand;
    result_i      <= op.result;
    carry_in_i    <= op.carry;
    count_i       <= op.count;
    flags_value_i <= op.load_val;
    push          <= 1'b1;
    do @(posedge clk_i); while (full);
    nxt          = next_flags(op, flags_shadow);
    flags_shadow = nxt;
    flags_due.push_back(typed ? want : nxt);
    op_seen[op.kind]++;
    ops_sent++;
  endtask

  task automatic check_flags(logic [11:0] got);
    logic [11:0] want;
    if (flags_due.size() == 0) begin
      flag_errors++;
      if (flag_errors <= ShownErrs) $display("Unexpected result transfer: flags %03h", got);
    end else begin
      want = flags_due.pop_front();
      results_checked++;
      if (got !== want) begin
        flag_errors++;
        if (flag_errors <= ShownErrs)
          $display("Flags mismatch on result %0d: expected %03h, got %03h",
                   results_checked, want, got);
      end
    end
  endtask

  // Result side: pops at random, except during the calm stretch.
  initial begin
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) check_flags(flags_o);
      pop <= calm || ($urandom_range(99) >= 27);
    end
  end

  initial begin
    int kinds;
    cycles        <= 0;
    rst_ni        <= 1'b0;
    push          <= 1'b0;
    req_type_i    <= OP_READ;
    size_code_i   <= SZ_BYTE;
    operand_i     <= '0;
    result_i      <= '0;
    carry_in_i    <= 1'b0;
    count_i       <= '0;
    flags_value_i <= '0;
    flags_shadow  = FL_RESET;
    calm          = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Known values first, then one row for each arithmetic corner.
    add_row(OP_READ,   SZ_BYTE,  '0, '0, 0, 0, 12'h000, 1, 12'h002);
    add_row(OP_LOAD,   SZ_BYTE,  '0, '0, 0, 0, 12'hFFF, 1, 12'hFD7);
    add_row(OP_SHL,    SZ_BYTE,  64'hFF, 64'hFF, 0, 0, 12'h000, 1, 12'hFD7);
    add_row(OP_ROR,    SZ_QWORD, '1, '1, 0, 0, 12'h000, 1, 12'hFD7);
    add_row(OP_LOAD,   SZ_BYTE,  '0, '0, 0, 0, 12'h000, 1, 12'h002);
    add_row(OP_LOGIC,  SZ_BYTE,  '0, '0, 0, 0, 12'h000, 1, 12'h046);
    add_row(OP_LOGIC,  SZ_QWORD, '0, 64'h8000_0000_0000_0000, 0, 0, 12'h000, 1, 12'h086);
    add_row(OP_MUL_OV, SZ_BYTE,  '0, '0, 1, 0, 12'h000, 1, 12'h887);
    add_row(OP_LOAD,   SZ_BYTE,  '0, '0, 0, 0, 12'h700, 1, 12'h702);
    add_row(OP_ADD,    SZ_BYTE,  64'h01, 64'h80, 0, 0, 12'h000, 0, '0);
    add_row(OP_ADC,    SZ_BYTE,  64'hFF, 64'hFF, 1, 0, 12'h000, 0, '0);
    add_row(OP_SUB,    SZ_WORD,  64'h1, 64'hFFFF, 0, 0, 12'h000, 0, '0);
    add_row(OP_SBB,    SZ_DWORD, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 1, 0, 12'h000, 0, '0);
    add_row(OP_INC,    SZ_BYTE,  '0, 64'h80, 0, 0, 12'h000, 0, '0);
    add_row(OP_DEC,    SZ_BYTE,  '0, 64'h7F, 0, 0, 12'h000, 0, '0);
    add_row(OP_NEG,    SZ_BYTE,  64'h80, 64'h80, 0, 0, 12'h000, 0, '0);
    add_row(OP_NEG,    SZ_QWORD, '0, '0, 0, 0, 12'h000, 0, '0);
    add_row(OP_SHL,    SZ_BYTE,  64'h81, 64'h02, 0, 1, 12'h000, 0, '0);
    add_row(OP_SHL,    SZ_BYTE,  64'hFF, 64'h00, 0, 9, 12'h000, 0, '0);
    add_row(OP_SAR,    SZ_WORD,  64'h8000, 64'hFFFF, 0, 20, 12'h000, 0, '0);
    add_row(OP_SHR,    SZ_QWORD, '1, 64'h7FFF_FFFF_FFFF_FFFF, 0, 1, 12'h000, 0, '0);
    add_row(OP_ROL,    SZ_BYTE,  64'h81, 64'h03, 0, 1, 12'h000, 0, '0);
    add_row(OP_ROR,    SZ_DWORD, 64'h1, 64'h8000_0000, 0, 1, 12'h000, 0, '0);
    add_row(OP_ROL,    SZ_BYTE,  64'h81, 64'h81, 0, 8, 12'h000, 0, '0);
    add_row(OP_READ,   SZ_QWORD, '1, '1, 1, 63, 12'hFFF, 0, '0);

    foreach (plan[i]) transfer_in(plan[i].op, plan[i].typed, plan[i].want);

    // Neither side idles during the middle stretch of the random part.
    for (int n = 0; n < RandomOps; n++) begin
      calm = (n >= 400 && n < 600);
      transfer_in(random_op(), 1'b0, '0);
    end
    calm = 1'b0;
    push <= 1'b0;

    while (flags_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    kinds = 0;
    foreach (op_seen[k]) if (op_seen[k] > 0) kinds++;
    $display("Ran %0d operations covering %0d of 16 kinds in %0d cycles.", ops_sent, kinds,
             cycles);
    $display("Checked %0d flag results, %0d errors.", results_checked, flag_errors);
    if (flag_errors == 0 && flags_due.size() == 0 && results_checked == ops_sent) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/afu_pkg.sv
design/afu_front.sv
design/afu_queue.sv
design/afu_back.sv
design/x86_arith_flags_unit.sv
tb/x86_arith_flags_unit_test.sv
